### hdl/ptzfe_pkg.sv
// ptzfe_pkg: shared types and constants for the PTZ command frame encoder.
// Holds the command codes, register indexes, frame constants and the frame
// descriptor passed from the front end through the queue to the serializer.
package ptzfe_pkg;

  // Frame layout
  localparam int FRAME_BYTES = 11;
  localparam int BODY_BYTES  = 8;    // bytes 1..8, covered by the checksum
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] HEAD_BYTE = 8'hA0;
  localparam logic [7:0] TAIL_BYTE = 8'hAF;

  // Register reset values
  localparam logic [7:0] DEVICE_ADDRESS_RST = 8'd1;
  localparam logic [3:0] SPEED_LEVEL_RST    = 4'd4;
  localparam logic [7:0] NO_CRUISE          = 8'hFF;

  // Configuration register indexes
  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_SPEED_LEVEL    = 1'b1;

  // Auxiliary device codes
  localparam logic [1:0] AUX_BRUSH = 2'd0;
  localparam logic [1:0] AUX_LAMP  = 2'd1;
  localparam logic [1:0] AUX_VIDEO = 2'd2;
  localparam logic [1:0] AUX_BAD   = 2'd3;

  typedef enum logic [4:0] {
    KIND_STOP         = 5'd0,
    KIND_LEFT         = 5'd1,
    KIND_RIGHT        = 5'd2,
    KIND_UP           = 5'd3,
    KIND_DOWN         = 5'd4,
    KIND_FOCUS_NEAR   = 5'd5,
    KIND_FOCUS_FAR    = 5'd6,
    KIND_ZOOM_IN      = 5'd7,
    KIND_ZOOM_OUT     = 5'd8,
    KIND_IRIS_OPEN    = 5'd9,
    KIND_IRIS_CLOSE   = 5'd10,
    KIND_PRESET_GO    = 5'd11,
    KIND_PRESET_SET   = 5'd12,
    KIND_CRUISE_RUN   = 5'd13,
    KIND_CRUISE_STOP  = 5'd14,
    KIND_CRUISE_DEL   = 5'd15,
    KIND_CRUISE_ENTER = 5'd16,
    KIND_CRUISE_CFG   = 5'd17,
    KIND_CRUISE_LEAVE = 5'd18,
    KIND_AUX_SET      = 5'd19,
    KIND_AUX_CLR      = 5'd20
  } kind_t;

  // One queued frame: body[0] is frame byte 1, body[7] is frame byte 8.
  typedef struct packed {
    logic                       rejected;
    logic [BODY_BYTES-1:0][7:0] body;
    logic [7:0]                 csum;
  } frame_desc_t;

endpackage

### hdl/ptzfe_front.sv
// ptzfe_front: accepts commands, holds the configuration registers and the
// current cruise id, and builds the frame descriptor for the queue.
// Depends on ptzfe_pkg.
module ptzfe_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [7:0]            cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [39:0]           in_tdata,
  input  logic                  q_full,
  output logic                  q_push,
  output ptzfe_pkg::frame_desc_t q_desc
);

  logic [7:0] device_address_r;
  logic [3:0] speed_level_r;
  logic [7:0] current_cruise_r;
  logic [7:0] current_cruise_nxt;

  logic [4:0] kind;
  logic [7:0] preset_id;
  logic [7:0] cruise_id;
  logic [7:0] cruise_speed;
  logic [7:0] wait_time;
  logic [1:0] aux_device;

  logic       accept;
  logic       emits;
  logic       rejected;
  logic [7:0] spd;
  logic [7:0] sum;
  logic [7:0] f [1:8];

  // Field unpacking
  assign kind         = in_tdata[4:0];
  assign preset_id    = in_tdata[12:5];
  assign cruise_id    = in_tdata[20:13];
  assign cruise_speed = in_tdata[28:21];
  assign wait_time    = in_tdata[36:29];
  assign aux_device   = in_tdata[38:37];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Pan/tilt speed byte: level*8-1, wrapping at eight bits
  assign spd = 8'({speed_level_r, 3'b000}) - 8'd1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r <= ptzfe_pkg::DEVICE_ADDRESS_RST;
      speed_level_r    <= ptzfe_pkg::SPEED_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ptzfe_pkg::CFG_DEVICE_ADDRESS: device_address_r <= cfg_wdata;
        ptzfe_pkg::CFG_SPEED_LEVEL:    speed_level_r    <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Command decode and frame body build
  always_comb begin
    emits              = 1'b1;
    rejected           = 1'b0;
    current_cruise_nxt = current_cruise_r;
    f[1] = device_address_r;
    f[2] = 8'h00;
    f[3] = 8'h00;
    f[4] = 8'h00;
    f[5] = 8'h00;
    f[6] = 8'h00;
    f[7] = 8'h00;
    f[8] = 8'hFF;
    // cruise and auxiliary frames share this head
    if (kind >= 5'(ptzfe_pkg::KIND_CRUISE_RUN)) begin
      f[2] = device_address_r;
      f[7] = 8'hFF;
    end
    unique case (ptzfe_pkg::kind_t'(kind))
      ptzfe_pkg::KIND_STOP: ;
      ptzfe_pkg::KIND_LEFT: begin
        f[4] = 8'h04;
        f[5] = spd;
      end
      ptzfe_pkg::KIND_RIGHT: begin
        f[4] = 8'h02;
        f[5] = spd;
      end
      ptzfe_pkg::KIND_UP: begin
        f[4] = 8'h08;
        f[6] = spd;
      end
      ptzfe_pkg::KIND_DOWN: begin
        f[4] = 8'h10;
        f[6] = spd;
      end
      ptzfe_pkg::KIND_FOCUS_NEAR: begin
        f[3] = 8'h02;
        f[7] = 8'h44;
      end
      ptzfe_pkg::KIND_FOCUS_FAR: begin
        f[3] = 8'h01;
        f[7] = 8'h44;
      end
      ptzfe_pkg::KIND_ZOOM_IN: begin
        f[4] = 8'h40;
        f[7] = 8'h44;
      end
      ptzfe_pkg::KIND_ZOOM_OUT: begin
        f[4] = 8'h20;
        f[7] = 8'h44;
      end
      ptzfe_pkg::KIND_IRIS_OPEN:  f[3] = 8'h10;
      ptzfe_pkg::KIND_IRIS_CLOSE: f[3] = 8'h08;
      ptzfe_pkg::KIND_PRESET_GO, ptzfe_pkg::KIND_PRESET_SET: begin
        f[2] = 8'h01;
        f[4] = (kind == 5'(ptzfe_pkg::KIND_PRESET_GO)) ? 8'h07 : 8'h03;
        f[5] = preset_id;
        f[6] = 8'hFF;
        f[7] = 8'hFF;
      end
      ptzfe_pkg::KIND_CRUISE_RUN: begin
        f[4] = 8'h21;
        f[5] = cruise_id;
      end
      ptzfe_pkg::KIND_CRUISE_STOP: begin
        f[4] = 8'h2F;
        f[5] = 8'hFF;
        f[6] = 8'hFF;
      end
      ptzfe_pkg::KIND_CRUISE_DEL: begin
        f[4] = 8'h2B;
        f[5] = 8'h01;
        f[6] = cruise_id;
      end
      ptzfe_pkg::KIND_CRUISE_ENTER: begin
        current_cruise_nxt = cruise_id;
        f[4] = 8'h23;
        f[5] = cruise_id;
        f[6] = 8'h80;
      end
      ptzfe_pkg::KIND_CRUISE_CFG: begin
        // an all-zero point is dropped
        emits = (preset_id != 8'h00) || (cruise_speed != 8'h00) || (wait_time != 8'h00);
        f[4] = 8'h23;
        f[5] = current_cruise_r;
        f[6] = preset_id;
        f[7] = cruise_speed;
        f[8] = wait_time;
      end
      ptzfe_pkg::KIND_CRUISE_LEAVE: begin
        f[4] = 8'h23;
        f[5] = cruise_id;
        f[6] = 8'h40;
      end
      ptzfe_pkg::KIND_AUX_SET, ptzfe_pkg::KIND_AUX_CLR: begin
        f[3] = 8'h80;
        f[4] = 8'h01;
        f[6] = (kind == 5'(ptzfe_pkg::KIND_AUX_SET)) ? 8'h01 : 8'h00;
        case (aux_device)
          ptzfe_pkg::AUX_BRUSH:
            f[5] = (kind == 5'(ptzfe_pkg::KIND_AUX_SET)) ? 8'h0C : 8'h0D;
          ptzfe_pkg::AUX_LAMP:  f[5] = 8'h0F;
          ptzfe_pkg::AUX_VIDEO: f[5] = 8'h0E;
          default:              rejected = 1'b1;
        endcase
      end
      default: emits = 1'b0;  // unused command codes
    endcase
  end

  // Checksum: complement of the byte sum over bytes 1..8
  assign sum = ((f[1] + f[2]) + (f[3] + f[4])) + ((f[5] + f[6]) + (f[7] + f[8]));

  // Descriptor assembly
  always_comb begin
    q_desc.rejected = rejected;
    q_desc.csum     = ~sum;
    for (int i = 0; i < ptzfe_pkg::BODY_BYTES; i++) begin
      q_desc.body[i] = f[i + 1];
    end
  end

  assign q_push = accept && emits;

  // Current cruise id
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_cruise_r <= ptzfe_pkg::NO_CRUISE;
    end else if (accept) begin
      current_cruise_r <= current_cruise_nxt;
    end
  end

  a_cruise_enter: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (kind == 5'(ptzfe_pkg::KIND_CRUISE_ENTER))
    |=> current_cruise_r == $past(cruise_id))
    else $error("cruise enter did not latch the cruise id");

endmodule

### hdl/ptzfe_queue.sv
// ptzfe_queue: short FIFO of frame descriptors between front end and
// serializer, so either side can stall on its own. Depends on ptzfe_pkg.
module ptzfe_queue #(
  parameter int DEPTH = ptzfe_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  ptzfe_pkg::frame_desc_t push_desc,
  input  logic                   pop,
  output logic                   full,
  output logic                   nonempty,
  output ptzfe_pkg::frame_desc_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ptzfe_pkg::frame_desc_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign nonempty = (count_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign head     = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into a full queue");

endmodule

### hdl/ptzfe_back.sv
// ptzfe_back: serializer. Pops a frame descriptor and sends its bytes one
// per transfer through a registered output stage. Depends on ptzfe_pkg.
module ptzfe_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_nonempty,
  input  ptzfe_pkg::frame_desc_t q_head,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,
  output logic                   out_tlast,
  output logic                   out_tuser
);

  localparam logic [3:0] LAST_IDX = 4'(ptzfe_pkg::FRAME_BYTES - 1);

  ptzfe_pkg::frame_desc_t cur_r;
  logic                   cur_vld_r;
  logic [3:0]             idx_r;
  logic                   out_vld_r;
  logic [7:0]             out_data_r;
  logic                   out_last_r;
  logic                   out_user_r;

  logic       load;
  logic       finish;
  logic [7:0] byte_nxt;

  assign load   = cur_vld_r && (!out_vld_r || out_tready);
  assign finish = cur_r.rejected || (idx_r == LAST_IDX);
  assign q_pop  = q_nonempty && (!cur_vld_r || (load && finish));

  // Byte select for the current position
  always_comb begin
    case (idx_r) inside
      4'd0:          byte_nxt = ptzfe_pkg::HEAD_BYTE;
      [4'd1:4'd8]:   byte_nxt = cur_r.body[3'(idx_r - 4'd1)];
      4'd9:          byte_nxt = ptzfe_pkg::TAIL_BYTE;
      default:       byte_nxt = cur_r.csum;
    endcase
    if (cur_r.rejected) begin
      byte_nxt = 8'h00;
    end
  end

  // Current frame and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      if (load) begin
        idx_r <= finish ? 4'd0 : idx_r + 4'd1;
      end
      if (q_pop) begin
        cur_vld_r <= 1'b1;
        idx_r     <= '0;
      end else if (load && finish) begin
        cur_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= byte_nxt;
      out_last_r <= finish;
      out_user_r <= cur_r.rejected;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == 8'h00))
    else $error("reject item with wrong shape");

  a_pop_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && cur_vld_r |-> load && finish)
    else $error("frame popped while the current one is unfinished");

endmodule

### hdl/ptz_command_frame_encoder_unit.sv
// Channel  | Dir | Width | Fields (low bit up)
// in_      | in  | 40    | kind[4:0] preset_id[12:5] cruise_id[20:13] cruise_speed[28:21]
//          |     |       | wait_time[36:29] aux_device[38:37], zero pad
// out_     | out | 8+1+1 | tdata frame_byte, tlast last_byte, tuser rejected
// cfg_     | in  | 1+8   | index 0 device_address, 1 speed_level
//
// A command makes an 11-byte frame (a reject one zero byte; a dropped one
// nothing), sent one byte per cycle while out_tready allows. The output register
// sets that pace. Commands are taken while the descriptor queue has room, and
// the front end builds each frame in the cycle it accepts the command.
// Reset (rst_n low, synchronous) empties the queue and serializer and restores
// register defaults; an output stall backs up into the queue, then in_tready.
module ptz_command_frame_encoder_unit #(
  parameter int QUEUE_DEPTH = ptzfe_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // kind, preset_id, cruise_id, cruise_speed, wait_time, aux_device
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // frame_byte
  output logic        out_tlast,
  output logic        out_tuser   // rejected
);

  ptzfe_pkg::frame_desc_t push_desc;
  ptzfe_pkg::frame_desc_t head;
  logic                   push;
  logic                   pop;
  logic                   full;
  logic                   nonempty;

  ptzfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (full),
    .q_push    (push),
    .q_desc    (push_desc)
  );

  ptzfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .full      (full),
    .nonempty  (nonempty),
    .head      (head)
  );

  ptzfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (nonempty),
    .q_head     (head),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
